// ----- hdl/haptic_angle_limit_spring_damper_defines.svh -----
// assertion macros for the angle limit spring-damper block
`ifndef HAPTIC_ANGLE_LIMIT_SPRING_DAMPER_DEFINES_SVH
`define HAPTIC_ANGLE_LIMIT_SPRING_DAMPER_DEFINES_SVH

// same-cycle implication, idle during reset
`define HALSD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// plain invariant, checked on every edge out of reset
`define HALSD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

// ----- hdl/halsd_pkg.sv -----
// package: widths, codes and constants of the angle limit spring-damper block
package halsd_pkg;

	localparam int ANGLE_W = 24;
	localparam int VEL_W   = 16;
	localparam int GAIN_W  = 16;
	localparam int DUTY_W  = 7;
	localparam int MODE_W  = 2;
	localparam int DIR_W   = 2;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 24;
	localparam int SETTLE_W  = 6;
	localparam int HOLDOFF_W = 7;

	localparam int AERR_W   = ANGLE_W + 1;
	localparam int SPRING_W = AERR_W + GAIN_W;
	localparam int DAMP_W   = VEL_W + GAIN_W;
	localparam int FORCE_W  = SPRING_W + 1;
	localparam int FRAC_W   = 16;
	localparam int WHOLE_W  = FORCE_W - FRAC_W;

	localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_UPPER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd2;

	localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

	localparam logic [IDX_W-1:0] REG_LIMIT_MODE   = 3'd0;
	localparam logic [IDX_W-1:0] REG_LOWER_BOUND  = 3'd1;
	localparam logic [IDX_W-1:0] REG_UPPER_BOUND  = 3'd2;
	localparam logic [IDX_W-1:0] REG_SPRING_GAIN  = 3'd3;
	localparam logic [IDX_W-1:0] REG_DAMPING_GAIN = 3'd4;
	localparam logic [IDX_W-1:0] REG_DUTY_CEILING = 3'd5;

	localparam logic [MODE_W-1:0]         RST_LIMIT_MODE   = MODE_BOTH;
	localparam logic signed [ANGLE_W-1:0] RST_LOWER_BOUND  = 24'sd0;
	localparam logic signed [ANGLE_W-1:0] RST_UPPER_BOUND  = 24'sd23040;
	localparam logic [GAIN_W-1:0]         RST_SPRING_GAIN  = 16'd2560;
	localparam logic [GAIN_W-1:0]         RST_DAMPING_GAIN = 16'd2560;
	localparam logic [DUTY_W-1:0]         RST_DUTY_CEILING = 7'd80;

	localparam logic [SETTLE_W-1:0]  SETTLE_TICKS  = 6'd50;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_TICKS = 7'd100;

	// 3 deg in Q.8 and 0.3 deg/ms in Q8.8
	localparam logic [AERR_W-1:0] SETTLE_ERR = 25'd768;
	localparam logic [VEL_W-1:0]  SETTLE_VEL = 16'd77;

	localparam logic [DUTY_W-1:0] DUTY_FLOOR = 7'd20;
	localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;

endpackage

// ----- hdl/haptic_angle_limit_spring_damper.sv -----
// top level: angle limit virtual wall with spring-damper drive
// a result passes the input, limit, multiplier and output registers before it is offered
// throughput: one item per cycle while out_stall is low, set by the bounce state update in the first stage
// stages: input register, limit and settle logic, gain multipliers, force clamp, output
// reset: arst_n clears the valid flags and bounce state and loads the register defaults asynchronously
// a config write to a defined register clears bounce and the settle run and keeps the announce holdoff
`include "haptic_angle_limit_spring_damper_defines.svh"

module haptic_angle_limit_spring_damper (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [halsd_pkg::IDX_W-1:0]            cfg_index,
	input  logic [halsd_pkg::DATA_W-1:0]           cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic signed [halsd_pkg::ANGLE_W-1:0]   angle,
	input  logic signed [halsd_pkg::VEL_W-1:0]     velocity,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [halsd_pkg::DIR_W-1:0]            drive_dir,
	output logic [halsd_pkg::DUTY_W-1:0]           duty,
	output logic                                   enter_event,
	output logic                                   exit_event,
	output logic                                   bouncing
);
	import halsd_pkg::*;

	// configuration
	logic [MODE_W-1:0]         limit_mode_q;
	logic signed [ANGLE_W-1:0] lower_bound_q;
	logic signed [ANGLE_W-1:0] upper_bound_q;
	logic [GAIN_W-1:0]         spring_gain_q;
	logic [GAIN_W-1:0]         damping_gain_q;
	logic [DUTY_W-1:0]         duty_ceiling_q;

	// bounce state
	logic                      bounce_q;
	logic signed [ANGLE_W-1:0] anchor_q;
	logic [SETTLE_W-1:0]       settle_q;
	logic [HOLDOFF_W-1:0]      holdoff_q;

	// pipeline
	logic                      valid_s1, valid_s2, valid_s3;
	logic signed [ANGLE_W-1:0] angle_s1;
	logic signed [VEL_W-1:0]   velocity_s1;
	logic [AERR_W-1:0]         aerr_s2;
	logic [VEL_W-1:0]          avel_s2;
	logic [DIR_W-1:0]          dir_s2, dir_s3;
	logic                      drive_s2, drive_s3;
	logic                      enter_s2, enter_s3;
	logic                      exit_s2, exit_s3;
	logic                      bouncing_s2, bouncing_s3;
	logic [SPRING_W-1:0]       spring_s3;
	logic [DAMP_W-1:0]         damp_s3;

	logic ready_out, ready_s3, ready_s2, ready_s1;
	logic step_s1;

	assign ready_out = !out_valid || !out_stall;
	assign ready_s3  = !valid_s3 || ready_out;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_stall  = !ready_s1;
	assign step_s1   = valid_s1 && ready_s2;

	// limit check and state update
	logic                      chk_up, chk_lo, hit_up, hit_lo;
	logic signed [ANGLE_W-1:0] anchor_cur;
	logic signed [AERR_W-1:0]  err;
	logic [AERR_W-1:0]         aerr;
	logic [VEL_W-1:0]          avel;
	logic                      settled;
	logic                      nx_bounce, nx_enter, nx_exit, nx_drive;
	logic [SETTLE_W-1:0]       nx_settle, settle_inc;
	logic [HOLDOFF_W-1:0]      nx_holdoff;

	assign chk_up = (limit_mode_q == MODE_UPPER) || (limit_mode_q == MODE_BOTH);
	assign chk_lo = (limit_mode_q == MODE_BOTH);
	assign hit_up = !bounce_q && chk_up && (angle_s1 > upper_bound_q);
	assign hit_lo = !bounce_q && !hit_up && chk_lo && (angle_s1 < lower_bound_q);
	assign anchor_cur = hit_up ? upper_bound_q : (hit_lo ? lower_bound_q : anchor_q);
	assign err  = {anchor_cur[ANGLE_W-1], anchor_cur} - {angle_s1[ANGLE_W-1], angle_s1};
	assign aerr = err[AERR_W-1] ? AERR_W'(-err) : AERR_W'(err);
	assign avel = velocity_s1[VEL_W-1] ? VEL_W'(-velocity_s1) : VEL_W'(velocity_s1);
	assign settled = (aerr < SETTLE_ERR) && (avel < SETTLE_VEL);

	always_comb begin
		nx_bounce  = bounce_q;
		nx_settle  = settle_q;
		nx_holdoff = holdoff_q;
		nx_enter   = 1'b0;
		nx_exit    = 1'b0;
		nx_drive   = 1'b0;
		settle_inc = '0;
		if (limit_mode_q == MODE_OFF) begin
			if (bounce_q) begin
				nx_bounce  = 1'b0;
				nx_holdoff = '0;
				nx_exit    = 1'b1;
			end
		end else begin
			if (hit_up || hit_lo) begin
				nx_bounce = 1'b1;
				nx_settle = '0;
				if (holdoff_q == '0) begin
					nx_enter   = 1'b1;
					nx_holdoff = HOLDOFF_TICKS;
				end
			end
			if (nx_holdoff != '0) begin
				nx_holdoff = nx_holdoff - 1'b1;
			end
			if (nx_bounce) begin
				nx_drive = 1'b1;
				if (settled) begin
					settle_inc = nx_settle + 1'b1;
					if (settle_inc >= SETTLE_TICKS) begin
						nx_bounce = 1'b0;
						nx_settle = '0;
						nx_exit   = 1'b1;
					end else begin
						nx_settle = settle_inc;
					end
				end else begin
					nx_settle = '0;
				end
			end
		end
	end

	// config registers and bounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_mode_q   <= RST_LIMIT_MODE;
			lower_bound_q  <= RST_LOWER_BOUND;
			upper_bound_q  <= RST_UPPER_BOUND;
			spring_gain_q  <= RST_SPRING_GAIN;
			damping_gain_q <= RST_DAMPING_GAIN;
			duty_ceiling_q <= RST_DUTY_CEILING;
			bounce_q       <= 1'b0;
			anchor_q       <= '0;
			settle_q       <= '0;
			holdoff_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LIMIT_MODE:   limit_mode_q   <= cfg_data[MODE_W-1:0];
				REG_LOWER_BOUND:  lower_bound_q  <= $signed(cfg_data[ANGLE_W-1:0]);
				REG_UPPER_BOUND:  upper_bound_q  <= $signed(cfg_data[ANGLE_W-1:0]);
				REG_SPRING_GAIN:  spring_gain_q  <= cfg_data[GAIN_W-1:0];
				REG_DAMPING_GAIN: damping_gain_q <= cfg_data[GAIN_W-1:0];
				REG_DUTY_CEILING: duty_ceiling_q <= cfg_data[DUTY_W-1:0];
				default: ;
			endcase
			if (cfg_index <= REG_DUTY_CEILING) begin
				bounce_q <= 1'b0;
				settle_q <= '0;
			end
		end else if (step_s1) begin
			bounce_q  <= nx_bounce;
			anchor_q  <= anchor_cur;
			settle_q  <= nx_settle;
			holdoff_q <= nx_holdoff;
		end
	end

	// force clamp
	logic signed [FORCE_W-1:0] force_q16;
	logic signed [WHOLE_W-1:0] whole, floored;
	logic [DUTY_W-1:0]         ceil_lim, duty_clamped;

	assign force_q16 = $signed({1'b0, spring_s3}) - $signed(FORCE_W'(damp_s3));
	assign whole     = force_q16[FORCE_W-1:FRAC_W];
	assign ceil_lim  = (duty_ceiling_q > DUTY_MAX) ? DUTY_MAX : duty_ceiling_q;
	assign floored   = (whole < $signed(WHOLE_W'(DUTY_FLOOR))) ?
		$signed(WHOLE_W'(DUTY_FLOOR)) : whole;
	assign duty_clamped = (floored > $signed(WHOLE_W'(ceil_lim))) ?
		ceil_lim : floored[DUTY_W-1:0];

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_s3  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
			if (ready_out) begin
				out_valid <= valid_s3;
			end
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			angle_s1    <= angle;
			velocity_s1 <= velocity;
		end
		if (step_s1) begin
			aerr_s2     <= aerr;
			avel_s2     <= avel;
			dir_s2      <= (err > 0) ? DIR_FWD : DIR_REV;
			drive_s2    <= nx_drive;
			enter_s2    <= nx_enter;
			exit_s2     <= nx_exit;
			bouncing_s2 <= nx_bounce;
		end
		if (valid_s2 && ready_s3) begin
			spring_s3   <= aerr_s2 * spring_gain_q;
			damp_s3     <= avel_s2 * damping_gain_q;
			dir_s3      <= dir_s2;
			drive_s3    <= drive_s2;
			enter_s3    <= enter_s2;
			exit_s3     <= exit_s2;
			bouncing_s3 <= bouncing_s2;
		end
		if (valid_s3 && ready_out) begin
			drive_dir   <= drive_s3 ? dir_s3 : DIR_STOP;
			duty        <= drive_s3 ? duty_clamped : '0;
			enter_event <= enter_s3;
			exit_event  <= exit_s3;
			bouncing    <= bouncing_s3;
		end
	end

	`HALSD_ASSERT_IMPL(a_stop_no_duty, out_valid && (drive_dir == DIR_STOP), duty == '0, "duty while stopped")
	`HALSD_ASSERT_IMPL(a_duty_range, out_valid, duty <= DUTY_MAX, "duty above full scale")
	`HALSD_ASSERT_IMPL(a_exit_clears, out_valid && exit_event, !bouncing, "bouncing after exit")
	`HALSD_ASSERT_ALWAYS(a_settle_range, settle_q < SETTLE_TICKS, "settle run past threshold")
	`HALSD_ASSERT_ALWAYS(a_holdoff_range, holdoff_q < HOLDOFF_TICKS, "holdoff not counted down")

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// testbench for the angle limit spring-damper block: random and directed samples checked per transfer

module tb_top;
	import halsd_pkg::*;

	localparam int PIPE_LAT = 3;
	localparam int HOLD_CYCLES = 200;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam longint ANGLE_MAX = (longint'(1) <<< (ANGLE_W - 1)) - 1;
	localparam longint ANGLE_MIN = -(longint'(1) <<< (ANGLE_W - 1));
	localparam longint VEL_MAX = (longint'(1) <<< (VEL_W - 1)) - 1;
	localparam longint VEL_MIN = -(longint'(1) <<< (VEL_W - 1));

	typedef struct {
		logic signed [ANGLE_W-1:0] ang;
		logic signed [VEL_W-1:0]   vel;
	} sample_t;

	typedef struct {
		logic [DIR_W-1:0]  dir;
		logic [DUTY_W-1:0] duty;
		logic              enter;
		logic              leave;
		logic              bounce;
	} wall_out_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [IDX_W-1:0]          cfg_index = '0;
	logic [DATA_W-1:0]         cfg_data = '0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic signed [ANGLE_W-1:0] angle = '0;
	logic signed [VEL_W-1:0]   velocity = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [DIR_W-1:0]          drive_dir;
	logic [DUTY_W-1:0]         duty;
	logic                      enter_event;
	logic                      exit_event;
	logic                      bouncing;

	// register copy
	logic [MODE_W-1:0]         cfg_mode = RST_LIMIT_MODE;
	logic signed [ANGLE_W-1:0] cfg_lower = RST_LOWER_BOUND;
	logic signed [ANGLE_W-1:0] cfg_upper = RST_UPPER_BOUND;
	logic [GAIN_W-1:0]         cfg_kp = RST_SPRING_GAIN;
	logic [GAIN_W-1:0]         cfg_kd = RST_DAMPING_GAIN;
	logic [DUTY_W-1:0]         cfg_ceiling = RST_DUTY_CEILING;

	// wall state
	logic                      wall_on = 1'b0;
	logic signed [ANGLE_W-1:0] wall_anchor = '0;
	logic [SETTLE_W-1:0]       settle_count = '0;
	logic [HOLDOFF_W-1:0]      holdoff_count = '0;

	sample_t   pending_samples[$];
	wall_out_t due_outputs[$];
	int        queued;
	int        fail_count = 0;
	int        results_seen = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        hold_left = 0;
	bit        hold_done = 1'b0;
	bit        in_taken = 1'b0;

	haptic_angle_limit_spring_damper u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.angle       (angle),
		.velocity    (velocity),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.drive_dir   (drive_dir),
		.duty        (duty),
		.enter_event (enter_event),
		.exit_event  (exit_event),
		.bouncing    (bouncing)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic wall_out_t wall_step(input logic signed [ANGLE_W-1:0] ang,
			input logic signed [VEL_W-1:0] vel);
		wall_out_t r;
		longint err, aerr, avel, force_q, ceil_q;
		logic hit;
		r.dir = DIR_STOP;
		r.duty = '0;
		r.enter = 1'b0;
		r.leave = 1'b0;
		r.bounce = 1'b0;
		if (cfg_mode == MODE_OFF) begin
			if (wall_on) begin
				wall_on = 1'b0;
				holdoff_count = '0;
				r.leave = 1'b1;
			end
		end else begin
			avel = (vel < 0) ? -longint'(vel) : longint'(vel);
			if (!wall_on) begin
				hit = 1'b0;
				if ((cfg_mode == MODE_UPPER || cfg_mode == MODE_BOTH) && ang > cfg_upper) begin
					hit = 1'b1;
					wall_anchor = cfg_upper;
				end else if (cfg_mode == MODE_BOTH && ang < cfg_lower) begin
					hit = 1'b1;
					wall_anchor = cfg_lower;
				end
				if (hit) begin
					wall_on = 1'b1;
					settle_count = '0;
					if (holdoff_count == 0) begin
						r.enter = 1'b1;
						holdoff_count = HOLDOFF_TICKS;
					end
				end
			end
			if (holdoff_count > 0)
				holdoff_count = holdoff_count - 1'b1;
			if (wall_on) begin
				err = longint'(wall_anchor) - longint'(ang);
				aerr = (err < 0) ? -err : err;
				force_q = aerr * longint'(cfg_kp) - avel * longint'(cfg_kd);
				ceil_q = longint'((cfg_ceiling > DUTY_MAX) ? DUTY_MAX : cfg_ceiling) <<< 16;
				// floor first, then the ceiling so a low ceiling wins
				if (force_q < (longint'(DUTY_FLOOR) <<< 16))
					force_q = longint'(DUTY_FLOOR) <<< 16;
				if (force_q > ceil_q)
					force_q = ceil_q;
				r.duty = DUTY_W'(force_q >>> 16);
				r.dir = (err > 0) ? DIR_FWD : DIR_REV;
				if (aerr < longint'(SETTLE_ERR) && avel < longint'(SETTLE_VEL)) begin
					settle_count = settle_count + 1'b1;
					if (settle_count >= SETTLE_TICKS) begin
						wall_on = 1'b0;
						settle_count = '0;
						r.leave = 1'b1;
					end
				end else begin
					settle_count = '0;
				end
			end
		end
		r.bounce = wall_on;
		return r;
	endfunction

	function automatic void push_sample(input longint a, input longint v);
		sample_t s;
		if (a > ANGLE_MAX)
			a = ANGLE_MAX;
		if (a < ANGLE_MIN)
			a = ANGLE_MIN;
		if (v > VEL_MAX)
			v = VEL_MAX;
		if (v < VEL_MIN)
			v = VEL_MIN;
		s.ang = a[ANGLE_W-1:0];
		s.vel = v[VEL_W-1:0];
		pending_samples.push_back(s);
		queued++;
	endfunction

	task automatic wait_idle();
		while (!(pending_samples.size() == 0 && !in_valid && due_outputs.size() == 0))
			@(posedge clk);
		repeat (PIPE_LAT + 3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input longint val);
		logic [DATA_W-1:0] data;
		logic known;
		data = val[DATA_W-1:0];
		known = 1'b1;
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_LIMIT_MODE:   cfg_mode = data[MODE_W-1:0];
			REG_LOWER_BOUND:  cfg_lower = data[ANGLE_W-1:0];
			REG_UPPER_BOUND:  cfg_upper = data[ANGLE_W-1:0];
			REG_SPRING_GAIN:  cfg_kp = data[GAIN_W-1:0];
			REG_DAMPING_GAIN: cfg_kd = data[GAIN_W-1:0];
			REG_DUTY_CEILING: cfg_ceiling = data[DUTY_W-1:0];
			default:          known = 1'b0;
		endcase
		// a write to a defined register drops the wall but keeps the holdoff
		if (known) begin
			wall_on = 1'b0;
			settle_count = '0;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly wall episodes: hit, push back, settle, drift inside; some raw noise between
	task automatic queue_random(input int count);
		logic use_lower;
		logic [31:0] rw;
		longint anc, sgn, reach, off, v;
		int n, r;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(99) < 85) begin
				use_lower = (cfg_mode == MODE_BOTH) && ($urandom_range(1) == 1);
				anc = use_lower ? longint'(cfg_lower) : longint'(cfg_upper);
				sgn = use_lower ? -1 : 1;
				if ($urandom_range(9) == 0)
					reach = longint'($urandom_range(2000000, 1));
				else
					reach = longint'($urandom_range(4000, 1));
				push_sample(anc + sgn * reach, longint'($urandom_range(6000)) - 3000);
				n = $urandom_range(6);
				repeat (n) begin
					reach = reach * longint'($urandom_range(90, 30)) / 100;
					push_sample(anc + sgn * reach, longint'($urandom_range(3000)) - 1500);
				end
				n = $urandom_range(70, 40);
				repeat (n) begin
					r = $urandom_range(99);
					if (r < 4) begin
						push_sample(anc + sgn * longint'($urandom_range(3000, 768)),
							longint'($urandom_range(100)) - 50);
					end else if (r < 8) begin
						off = $urandom_range(1) ? 767 : 768;
						v = $urandom_range(1) ? 76 : 77;
						if ($urandom_range(1))
							off = -off;
						if ($urandom_range(1))
							v = -v;
						push_sample(anc + off, v);
					end else begin
						push_sample(anc + longint'($urandom_range(1400)) - 700,
							longint'($urandom_range(152)) - 76);
					end
				end
				n = $urandom_range(5);
				repeat (n)
					push_sample(anc - sgn * longint'($urandom_range(3000)),
						longint'($urandom_range(200)) - 100);
			end else begin
				n = $urandom_range(4, 1);
				repeat (n) begin
					rw = $urandom();
					r = $urandom_range(99);
					if (r < 10)
						v = $urandom_range(1) ? VEL_MAX : VEL_MIN;
					else
						v = longint'($signed(rw[31:16]));
					if (r >= 90)
						push_sample($urandom_range(1) ? ANGLE_MAX : ANGLE_MIN, v);
					else
						push_sample(longint'($signed(rw[23:0])), v);
				end
			end
		end
	endtask

	// sender: a new sample once the last one has gone
	always @(negedge clk) begin : drive
		sample_t s;
		if (!in_valid || in_taken) begin
			if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				s = pending_samples.pop_front();
				in_valid <= 1'b1;
				angle <= s.ang;
				velocity <= s.vel;
			end else begin
				in_valid <= 1'b0;
			end
		end
		in_taken = 1'b0;
	end

	// receiver stall, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!hold_done && results_seen >= 100) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin : watch
		wall_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (due_outputs.size() == 0) begin
				$error("result transfer with nothing outstanding");
				fail_count++;
			end else begin
				want = due_outputs.pop_front();
				if (drive_dir !== want.dir) begin
					$error("drive_dir: expected %0d, got %0d", want.dir, drive_dir);
					fail_count++;
				end
				if (duty !== want.duty) begin
					$error("duty: expected %0d, got %0d", want.duty, duty);
					fail_count++;
				end
				if (enter_event !== want.enter) begin
					$error("enter_event: expected %0d, got %0d", want.enter, enter_event);
					fail_count++;
				end
				if (exit_event !== want.leave) begin
					$error("exit_event: expected %0d, got %0d", want.leave, exit_event);
					fail_count++;
				end
				if (bouncing !== want.bounce) begin
					$error("bouncing: expected %0d, got %0d", want.bounce, bouncing);
					fail_count++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			due_outputs.push_back(wall_step(angle, velocity));
			in_taken = 1'b1;
		end
	end

	initial begin
		int r;
		send_idle_pct = 29;
		recv_idle_pct = 68;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// default registers: both bounds, 0 to 90 deg
		push_sample(0, 0);
		push_sample(23040, 0);
		push_sample(23041, 0);
		push_sample(23040, 0);
		push_sample(23040 + 767, 76);
		push_sample(23040 + 768, 0);
		push_sample(23040, 77);
		push_sample(23040 + 767, -76);
		push_sample(ANGLE_MAX, VEL_MAX);
		push_sample(ANGLE_MIN, VEL_MIN);
		push_sample(23040 - 768, VEL_MAX);
		push_sample(-1, 0);
		push_sample(23040 - 767, -1);
		wait_idle();
		queue_random(250);
		wait_idle();

		// upper only at the lowest angle, full spring, no damping, ceiling over 100
		write_reg(REG_LIMIT_MODE, MODE_UPPER);
		write_reg(REG_UPPER_BOUND, ANGLE_MIN);
		write_reg(REG_LOWER_BOUND, ANGLE_MAX);
		write_reg(REG_SPRING_GAIN, 65535);
		write_reg(REG_DAMPING_GAIN, 0);
		write_reg(REG_DUTY_CEILING, 127);
		queue_random(150);
		wait_idle();

		// crossed bounds, no spring, full damping, zero ceiling
		write_reg(REG_LIMIT_MODE, MODE_BOTH);
		write_reg(REG_LOWER_BOUND, 1000);
		write_reg(REG_UPPER_BOUND, -1000);
		write_reg(REG_SPRING_GAIN, 0);
		write_reg(REG_DAMPING_GAIN, 65535);
		write_reg(REG_DUTY_CEILING, 0);
		queue_random(150);
		wait_idle();

		write_reg(REG_LIMIT_MODE, MODE_NONE);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		write_reg(REG_DUTY_CEILING, 100);
		queue_random(60);
		wait_idle();

		send_idle_pct = 68;
		recv_idle_pct = 29;
		write_reg(REG_LIMIT_MODE, MODE_OFF);
		queue_random(60);
		wait_idle();

		write_reg(REG_LIMIT_MODE, MODE_BOTH);
		write_reg(REG_LOWER_BOUND, ANGLE_MIN);
		write_reg(REG_UPPER_BOUND, ANGLE_MAX);
		write_reg(REG_SPRING_GAIN, RST_SPRING_GAIN);
		write_reg(REG_DAMPING_GAIN, RST_DAMPING_GAIN);
		queue_random(40);
		wait_idle();

		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			r = $urandom_range(99);
			if (r < 60)
				write_reg(REG_LIMIT_MODE, MODE_BOTH);
			else if (r < 85)
				write_reg(REG_LIMIT_MODE, MODE_UPPER);
			else if (r < 93)
				write_reg(REG_LIMIT_MODE, MODE_OFF);
			else
				write_reg(REG_LIMIT_MODE, MODE_NONE);
			write_reg(REG_LOWER_BOUND, -longint'($urandom_range(40000)));
			write_reg(REG_UPPER_BOUND, longint'($urandom_range(40000)));
			write_reg(REG_SPRING_GAIN,
				$urandom_range(1) ? $urandom_range(4096) : $urandom_range(65535));
			write_reg(REG_DAMPING_GAIN,
				$urandom_range(1) ? $urandom_range(4096) : $urandom_range(65535));
			write_reg(REG_DUTY_CEILING, $urandom_range(127));
			queue_random(125);
			wait_idle();
		end

		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/halsd_pkg.sv
hdl/haptic_angle_limit_spring_damper.sv
verif/tb_top.sv
